[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication property checked on every rising edge.
`define SMM_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen high.
`define SMM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SMM_ASSERT_PROP(lbl, prop, msg)
`define SMM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/core/smm_pkg.sv]
`timescale 1ns / 1ps

package smm_pkg;

  // Matrix geometry
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

  // Item kinds
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row_res;
    logic [IDX_W-1:0]         col_res;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
  } out_item_t;

  // One step of the product walk, sequencer to MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_out;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } seq_ctl_t;

endpackage

[rtl/core/smm_ram.sv]
`timescale 1ns / 1ps

module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read with enable
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/smm_seq.sv]
`timescale 1ns / 1ps

module smm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         en,
  input  logic [smm_pkg::IDX_W-1:0]    n_m1,
  output logic [smm_pkg::ADDR_W-1:0]   addr_a,
  output logic [smm_pkg::ADDR_W-1:0]   addr_b,
  output smm_pkg::seq_ctl_t            ctl,
  output logic                         busy
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                  state_r, state_nxt;
  logic [smm_pkg::IDX_W-1:0]   i_r, i_nxt;
  logic [smm_pkg::IDX_W-1:0]   j_r, j_nxt;
  logic [smm_pkg::IDX_W-1:0]   k_r, k_nxt;

  // Current step, read addresses follow the counters directly
  always_comb begin
    ctl.valid    = (state_r == SEQ_RUN);
    ctl.first    = (k_r == '0);
    ctl.last_k   = (k_r == n_m1);
    ctl.last_out = (i_r == n_m1) && (j_r == n_m1);
    ctl.i        = i_r;
    ctl.j        = j_r;
    addr_a       = {i_r, k_r};
    addr_b       = {k_r, j_r};
    busy         = (state_r == SEQ_RUN);
  end

  // Walk i, j, k with k innermost; hold while the pipeline is stalled
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (en) begin
          if (k_r != n_m1) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (j_r != n_m1) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (i_r != n_m1) begin
                i_nxt = i_r + 1'b1;
              end else begin
                i_nxt     = '0;
                state_nxt = SEQ_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

[rtl/core/smm_mac.sv]
`timescale 1ns / 1ps

module smm_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smm_pkg::seq_ctl_t             seq_ctl,
  input  logic [smm_pkg::DATA_W-1:0]    a_data,
  input  logic [smm_pkg::DATA_W-1:0]    b_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output smm_pkg::out_item_t            out_data,
  output logic                          en,
  output logic                          busy
);

  smm_pkg::seq_ctl_t               ctl1_r, ctl2_r;
  logic [smm_pkg::DATA_W-1:0]      prod_r;
  logic [smm_pkg::DATA_W-1:0]      acc_r;
  logic [smm_pkg::DATA_W-1:0]      acc_nxt;
  logic                            out_valid_r;
  smm_pkg::out_item_t              out_data_r;

  // Whole pipeline advances unless a result is held by the consumer
  assign en   = !out_valid_r || !out_stall;
  assign busy = ctl1_r.valid || ctl2_r.valid;

  // Sum restarts on the first term of every dot product, wraps mod 2^32
  assign acc_nxt = (ctl2_r.first ? '0 : acc_r) + prod_r;

  // Control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl1_r      <= seq_ctl;
      ctl2_r      <= ctl1_r;
      out_valid_r <= ctl2_r.valid && ctl2_r.last_k;
    end
  end

  // Multiply (low word only), then accumulate and load the result register
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= smm_pkg::DATA_W'(a_data * b_data);
      if (ctl2_r.valid) begin
        acc_r <= acc_nxt;
      end
      out_data_r.row_res   <= ctl2_r.i;
      out_data_r.col_res   <= ctl2_r.j;
      out_data_r.value_res <= acc_nxt;
      out_data_r.last      <= ctl2_r.last_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/square_matrix_multiply.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Square matrix multiplier, C = A * B over n x n signed 32-bit elements, n
// from cfg_wdata clamped to 1..8. A load item (kind 0 for A, 1 for B)
// writes one element; it gives no result. A compute item walks all n^3
// products through one multiply-accumulate fed by one read of each matrix
// memory per cycle while out_stall does not hold the pipeline, so it occupies
// the block until the last sum has drained from the pipeline. Results leave
// in row-major order with last on C[n-1][n-1]; sums wrap modulo 2^32.
// in_stall stays high while a product is in progress. Reading an element
// that was never loaded gives an undefined value.
module square_matrix_multiply (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [smm_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  smm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output smm_pkg::out_item_t            out_data
);

  logic [smm_pkg::SIZE_W-1:0]   size_r;
  logic [smm_pkg::SIZE_W-1:0]   n_eff;
  logic [smm_pkg::IDX_W-1:0]    n_m1;
  logic                         in_xfer;
  logic                         in_range;
  logic                         we_a, we_b;
  logic                         start;
  logic [smm_pkg::ADDR_W-1:0]   waddr;
  logic [smm_pkg::ADDR_W-1:0]   addr_a, addr_b;
  logic [smm_pkg::DATA_W-1:0]   a_data, b_data;
  smm_pkg::seq_ctl_t            seq_ctl;
  logic                         seq_busy;
  logic                         mac_en;
  logic                         mac_busy;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= smm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Clamp size to 1..MAX_DIM
  always_comb begin
    if (size_r == '0) begin
      n_eff = smm_pkg::SIZE_W'(1);
    end else if (size_r > smm_pkg::SIZE_W'(smm_pkg::MAX_DIM)) begin
      n_eff = smm_pkg::SIZE_W'(smm_pkg::MAX_DIM);
    end else begin
      n_eff = size_r;
    end
  end
  assign n_m1 = smm_pkg::IDX_W'(n_eff - 1'b1);

  // Input transfer decode
  assign in_stall = seq_busy || mac_busy;
  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (int'(in_data.row) < smm_pkg::MAX_DIM) &&
                    (int'(in_data.col) < smm_pkg::MAX_DIM);
  assign we_a     = in_xfer && in_range && (in_data.kind == smm_pkg::KIND_LOAD_A);
  assign we_b     = in_xfer && in_range && (in_data.kind == smm_pkg::KIND_LOAD_B);
  assign start    = in_xfer && (in_data.kind == smm_pkg::KIND_COMPUTE);
  assign waddr    = {in_data.row, in_data.col};

  // Matrix memories
  smm_ram #(
    .WIDTH (smm_pkg::DATA_W),
    .DEPTH (smm_pkg::CELLS)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_data.value),
    .re    (mac_en),
    .raddr (addr_a),
    .rdata (a_data)
  );

  smm_ram #(
    .WIDTH (smm_pkg::DATA_W),
    .DEPTH (smm_pkg::CELLS)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_data.value),
    .re    (mac_en),
    .raddr (addr_b),
    .rdata (b_data)
  );

  // Product walk
  smm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .en     (mac_en),
    .n_m1   (n_m1),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .ctl    (seq_ctl),
    .busy   (seq_busy)
  );

  // Multiply-accumulate and result register
  smm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq_ctl   (seq_ctl),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .en        (mac_en),
    .busy      (mac_busy)
  );

  // Checks
  `SMM_ASSERT_NEVER(a_no_xfer_while_busy, in_xfer && (seq_busy || mac_busy), "busy xfer")
  `SMM_ASSERT_PROP(a_walk_holds, (seq_busy && !mac_en) |=> $stable(seq_ctl), "walk moved")
  `SMM_ASSERT_PROP(a_result_from_pipe, $rose(out_valid) |-> $past(mac_busy), "stray result")

endmodule
